### rtl/dwgs_pkg.sv
package dwgs_pkg;

  // Grid geometry and storage
  localparam int MAX_ROWS    = 128;
  localparam int MAX_COLS    = 128;
  localparam int HEIGHT_BITS = 16;
  localparam int CELLS       = MAX_ROWS * MAX_COLS;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int ADDR_W      = ROW_W + COL_W;

  // Field and register widths
  localparam int FUNC_W    = 2;
  localparam int ELAPSED_W = 16;
  localparam int MAG_W     = 16;
  localparam int OUT_H_W   = 16;
  localparam int DIM_W     = 8;
  localparam int PERIOD_W  = 16;
  localparam int COEF_W    = 20;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int TACC_W    = 17;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DISTURB = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SPARE   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CURR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_NEIGH  = 3'd5;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic signed [HEIGHT_BITS-1:0] height_t;

  // Cell (r,c) sits at r*MAX_COLS+c
  function automatic addr_t cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return {r, c};
  endfunction

endpackage

### rtl/dwgs_ram.sv
module dwgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/damped_wave_grid_step_unit.sv
// Channel  | handshake             | word
// ---------+-----------------------+--------------------------------------------
// request  | req_valid / req_stall | func, elapsed, row, col, magnitude
// response | rsp_valid / rsp_stall | height, stepped, fault
// config   | cfg_we                | cfg_index, cfg_data
//
// After reset a clearing pass zeroes both height banks, one cell a cycle;
// req_stall stays high meanwhile, config writes are taken. One request at
// a time. A stepping tick sweeps the interior through one shared multiplier,
// three products per cell, row by row. A finished word waits in the response
// register; the next request is taken while it waits, and its own result
// holds until the register frees up.
module damped_wave_grid_step_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [dwgs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dwgs_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  logic [dwgs_pkg::FUNC_W-1:0]            func,
  input  logic [dwgs_pkg::ELAPSED_W-1:0]         elapsed,
  input  logic [dwgs_pkg::ROW_W-1:0]             row,
  input  logic [dwgs_pkg::COL_W-1:0]             col,
  input  logic signed [dwgs_pkg::MAG_W-1:0]      magnitude,
  output logic                                   rsp_valid,
  input  logic                                   rsp_stall,
  output logic signed [dwgs_pkg::OUT_H_W-1:0]    height,
  output logic                                   stepped,
  output logic                                   fault
);

  import dwgs_pkg::*;

  localparam int NSUM_W = HEIGHT_BITS + 2;
  localparam int PROD_W = COEF_W + NSUM_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int FRAC   = 16;

  localparam height_t H_MAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
  localparam height_t H_MIN = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
  localparam logic signed [OUT_H_W-1:0] O_MAX = {1'b0, {(OUT_H_W-1){1'b1}}};
  localparam logic signed [OUT_H_W-1:0] O_MIN = {1'b1, {(OUT_H_W-1){1'b0}}};
  localparam logic [TACC_W-1:0] TACC_MAX = '1;
  localparam logic [DIM_W-1:0]  DIM_MIN  = 8'd5;
  localparam logic [DIM_W-1:0]  ROWS_MAX = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0]  COLS_MAX = DIM_W'(MAX_COLS);

  // Per-cell sweep phases
  localparam logic [3:0] PH_ISSUE = 4'd0;
  localparam logic [3:0] PH_UP    = 4'd1;
  localparam logic [3:0] PH_DOWN  = 4'd2;
  localparam logic [3:0] PH_LEFT  = 4'd3;
  localparam logic [3:0] PH_RIGHT = 4'd4;
  localparam logic [3:0] PH_SELF  = 4'd5;
  localparam logic [3:0] PH_MCUR  = 4'd6;
  localparam logic [3:0] PH_SUM   = 4'd7;
  localparam logic [3:0] PH_WRITE = 4'd8;

  localparam logic [2:0] D_CENTER = 3'd0;
  localparam logic [2:0] D_RIGHT  = 3'd1;
  localparam logic [2:0] D_LEFT   = 3'd2;
  localparam logic [2:0] D_BELOW  = 3'd3;
  localparam logic [2:0] D_ABOVE  = 3'd4;
  localparam logic [2:0] D_DONE   = 3'd5;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_STEP  = 6'b000100,
    ST_DIST  = 6'b001000,
    ST_READ  = 6'b010000,
    ST_RESP  = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers
  logic [DIM_W-1:0]           grid_rows;
  logic [DIM_W-1:0]           grid_cols;
  logic [PERIOD_W-1:0]        step_period;
  logic signed [COEF_W-1:0]   coef_prev;
  logic signed [COEF_W-1:0]   coef_curr;
  logic signed [COEF_W-1:0]   coef_neighbors;

  // Control and datapath registers
  logic [TACC_W-1:0]          time_acc;
  logic                       bank_sel;
  addr_t                      clr_addr;
  logic [ROW_W-1:0]           r_idx;
  logic [COL_W-1:0]           c_idx;
  logic [3:0]                 phase;
  logic signed [NSUM_W-1:0]   nsum;
  height_t                    prv_q;
  height_t                    cur_q;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SUM_W-1:0]    acc;
  logic [2:0]                 dcnt;
  addr_t                      dbase;
  height_t                    mag_q;
  logic signed [OUT_H_W-1:0]  res_height;
  logic                       res_stepped;
  logic                       res_fault;

  // Combinational
  logic [DIM_W-1:0]           rows_c;
  logic [DIM_W-1:0]           cols_c;
  logic [TACC_W:0]            tsum;
  logic [TACC_W-1:0]          tsat;
  logic                       step_now;
  logic                       dist_ok;
  logic                       read_ok;
  addr_t                      step_addr;
  addr_t                      cur_raddr;
  addr_t                      prv_raddr;
  addr_t                      wr_addr;
  height_t                    wr_data;
  logic                       wr_cur;
  logic                       wr_prv;
  logic                       clear_we;
  logic                       we_a;
  logic                       we_b;
  addr_t                      raddr_a;
  addr_t                      raddr_b;
  height_t                    rdata_a;
  height_t                    rdata_b;
  height_t                    cur_rdata;
  height_t                    prv_rdata;
  logic signed [COEF_W-1:0]   mul_a;
  logic signed [NSUM_W-1:0]   mul_b;
  logic                       mul_en;
  height_t                    half_mag;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] mx);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_MIN) r = DIM_MIN;
    else if (v > mx) r = mx;
    return r;
  endfunction

  function automatic height_t sat_add(height_t h, height_t a);
    logic signed [HEIGHT_BITS:0] s;
    height_t r;
    s = (HEIGHT_BITS+1)'(h) + (HEIGHT_BITS+1)'(a);
    r = s[HEIGHT_BITS-1:0];
    if (s[HEIGHT_BITS] != s[HEIGHT_BITS-1]) r = s[HEIGHT_BITS] ? H_MIN : H_MAX;
    return r;
  endfunction

  function automatic height_t sat_round(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    logic signed [SUM_W-1:0] sh;
    height_t r;
    t  = v + SUM_W'(32'sd32768);
    sh = t >>> FRAC;
    r  = sh[HEIGHT_BITS-1:0];
    if (sh > SUM_W'(H_MAX)) r = H_MAX;
    else if (sh < SUM_W'(H_MIN)) r = H_MIN;
    return r;
  endfunction

  function automatic logic signed [OUT_H_W-1:0] sat_read(height_t h);
    logic signed [31:0] w;
    logic signed [OUT_H_W-1:0] r;
    w = 32'(h);
    r = w[OUT_H_W-1:0];
    if (w > 32'(O_MAX)) r = O_MAX;
    else if (w < 32'(O_MIN)) r = O_MIN;
    return r;
  endfunction

  function automatic addr_t dist_addr(addr_t base, logic [2:0] k);
    addr_t r;
    unique case (k)
      D_RIGHT: r = base + ADDR_W'(1);
      D_LEFT:  r = base - ADDR_W'(1);
      D_BELOW: r = base + ADDR_W'(MAX_COLS);
      D_ABOVE: r = base - ADDR_W'(MAX_COLS);
      default: r = base;
    endcase
    return r;
  endfunction

  // Decode the request word
  assign rows_c    = clamp_dim(grid_rows, ROWS_MAX);
  assign cols_c    = clamp_dim(grid_cols, COLS_MAX);
  assign tsum      = (TACC_W+1)'(time_acc) + (TACC_W+1)'(elapsed);
  assign tsat      = tsum[TACC_W] ? TACC_MAX : tsum[TACC_W-1:0];
  assign step_now  = tsat >= TACC_W'(step_period);
  assign dist_ok   = (DIM_W'(row) > DIM_W'(1)) && (DIM_W'(row) + DIM_W'(2) < rows_c) &&
                     (DIM_W'(col) > DIM_W'(1)) && (DIM_W'(col) + DIM_W'(2) < cols_c);
  assign read_ok   = (DIM_W'(row) < rows_c) && (DIM_W'(col) < cols_c);
  assign step_addr = cell_addr(r_idx, c_idx);
  assign half_mag  = mag_q >>> 1;
  assign req_stall = (state != ST_IDLE);

  // Route reads and writes to the current and previous banks
  always_comb begin
    cur_raddr = cell_addr(row, col);
    prv_raddr = step_addr;
    wr_cur    = 1'b0;
    wr_prv    = 1'b0;
    wr_addr   = step_addr;
    wr_data   = sat_round(acc);
    unique case (state)
      ST_CLEAR: begin
        wr_addr = clr_addr;
        wr_data = '0;
      end
      ST_STEP: begin
        unique case (phase)
          PH_ISSUE: cur_raddr = step_addr - ADDR_W'(MAX_COLS);
          PH_UP:    cur_raddr = step_addr + ADDR_W'(MAX_COLS);
          PH_DOWN:  cur_raddr = step_addr - ADDR_W'(1);
          PH_LEFT:  cur_raddr = step_addr + ADDR_W'(1);
          default:  cur_raddr = step_addr;
        endcase
        wr_prv = (phase == PH_WRITE);
      end
      ST_DIST: begin
        cur_raddr = dist_addr(dbase, dcnt);
        if (dcnt != D_CENTER) begin
          wr_cur  = 1'b1;
          wr_addr = dist_addr(dbase, dcnt - 3'd1);
          wr_data = sat_add(cur_rdata, (dcnt == D_RIGHT) ? mag_q : half_mag);
        end
      end
      default: ;
    endcase
  end

  assign clear_we  = (state == ST_CLEAR);
  assign we_a      = clear_we | (bank_sel ? wr_prv : wr_cur);
  assign we_b      = clear_we | (bank_sel ? wr_cur : wr_prv);
  assign raddr_a   = bank_sel ? prv_raddr : cur_raddr;
  assign raddr_b   = bank_sel ? cur_raddr : prv_raddr;
  assign cur_rdata = bank_sel ? rdata_b : rdata_a;
  assign prv_rdata = bank_sel ? rdata_a : rdata_b;

  dwgs_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(CELLS)) u_bank_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  dwgs_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(CELLS)) u_bank_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // Select operands of the shared multiplier
  always_comb begin
    mul_a  = coef_prev;
    mul_b  = NSUM_W'(prv_q);
    mul_en = 1'b0;
    if (state == ST_STEP) begin
      unique case (phase)
        PH_DOWN: mul_en = 1'b1;
        PH_SELF: begin
          mul_a  = coef_neighbors;
          mul_b  = nsum;
          mul_en = 1'b1;
        end
        PH_MCUR: begin
          mul_a  = coef_curr;
          mul_b  = NSUM_W'(cur_q);
          mul_en = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  // Sequence clearing, sweeps, disturbs, reads and the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      time_acc       <= '0;
      bank_sel       <= 1'b0;
      rsp_valid      <= 1'b0;
      grid_rows      <= 8'd128;
      grid_cols      <= 8'd128;
      step_period    <= 16'd30;
      coef_prev      <= 20'sd131072;
      coef_curr      <= -20'sd65536;
      coef_neighbors <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_ROWS:   grid_rows      <= cfg_data[DIM_W-1:0];
          REG_GRID_COLS:   grid_cols      <= cfg_data[DIM_W-1:0];
          REG_STEP_PERIOD: step_period    <= cfg_data[PERIOD_W-1:0];
          REG_COEF_PREV:   coef_prev      <= cfg_data[COEF_W-1:0];
          REG_COEF_CURR:   coef_curr      <= cfg_data[COEF_W-1:0];
          REG_COEF_NEIGH:  coef_neighbors <= cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end

      // Drop a taken word; the response state reloads the register itself
      if (rsp_valid && !rsp_stall && (state != ST_RESP)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (req_valid) begin
            res_height  <= '0;
            res_stepped <= (func == FUNC_TICK) && step_now;
            res_fault   <= ((func == FUNC_DISTURB) && !dist_ok) ||
                           ((func == FUNC_READ) && !read_ok);
            priority if (func == FUNC_TICK) begin
              if (step_now) begin
                time_acc    <= '0;
                r_idx       <= ROW_W'(1);
                c_idx       <= COL_W'(1);
                phase       <= PH_ISSUE;
                state       <= ST_STEP;
              end else begin
                time_acc <= tsat;
                state    <= ST_RESP;
              end
            end else if (func == FUNC_DISTURB) begin
              if (dist_ok) begin
                dbase <= cell_addr(row, col);
                mag_q <= HEIGHT_BITS'(magnitude);
                dcnt  <= D_CENTER;
                state <= ST_DIST;
              end else begin
                state     <= ST_RESP;
              end
            end else if (func == FUNC_READ) begin
              if (read_ok) begin
                state <= ST_READ;
              end else begin
                state     <= ST_RESP;
              end
            end else begin
              state <= ST_RESP;
            end
          end
        end

        ST_STEP: begin
          phase <= (phase == PH_WRITE) ? PH_ISSUE : phase + 4'd1;
          unique case (phase)
            PH_UP: begin
              prv_q <= prv_rdata;
              nsum  <= NSUM_W'(cur_rdata);
            end
            PH_DOWN: nsum <= nsum + NSUM_W'(cur_rdata);
            PH_LEFT: begin
              nsum <= nsum + NSUM_W'(cur_rdata);
              acc  <= SUM_W'(prod);
            end
            PH_RIGHT: nsum <= nsum + NSUM_W'(cur_rdata);
            PH_SELF: cur_q <= cur_rdata;
            PH_MCUR: acc <= acc + SUM_W'(prod);
            PH_SUM:  acc <= acc + SUM_W'(prod);
            PH_WRITE: begin
              if (DIM_W'(c_idx) == cols_c - DIM_W'(2)) begin
                c_idx <= COL_W'(1);
                if (DIM_W'(r_idx) == rows_c - DIM_W'(2)) begin
                  bank_sel <= ~bank_sel;
                  state    <= ST_RESP;
                end else begin
                  r_idx <= r_idx + ROW_W'(1);
                end
              end else begin
                c_idx <= c_idx + COL_W'(1);
              end
            end
            default: ;
          endcase
        end

        ST_DIST: begin
          dcnt <= dcnt + 3'd1;
          if (dcnt == D_DONE) begin
            state <= ST_RESP;
          end
        end

        ST_READ: begin
          res_height <= sat_read(cur_rdata);
          state      <= ST_RESP;
        end

        ST_RESP: begin
          // Hand the word over once the response register is free
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            height    <= res_height;
            stepped   <= res_stepped;
            fault     <= res_fault;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/dwgs_checker.sv
module dwgs_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_stall,
  input logic                                rsp_valid,
  input logic                                rsp_stall,
  input logic signed [dwgs_pkg::OUT_H_W-1:0] height,
  input logic                                stepped,
  input logic                                fault
);

  import dwgs_pkg::*;

  // Hold a stalled response word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(height) && $stable(stepped) &&
    $stable(fault))
    else $error("response word changed while stalled");

  // Take one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken in back-to-back cycles");

  // Step and fault come from different operations
  a_flags_apart: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(stepped && fault))
    else $error("stepped and fault both set");

  // A height only comes with a clean read
  a_height_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (height != '0) |-> !fault && !stepped)
    else $error("nonzero height with a flag set");

endmodule

bind damped_wave_grid_step_unit dwgs_checker u_dwgs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .height    (height),
  .stepped   (stepped),
  .fault     (fault)
);
